// ===== rtl/frustum_cull_sphere_box_defines.svh =====
// Assertion macros shared by the frustum cull RTL
`ifndef FRUSTUM_CULL_SPHERE_BOX_DEFINES_SVH
`define FRUSTUM_CULL_SPHERE_BOX_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define FCSB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define FCSB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fcsb_pkg.sv =====
// Constants and types for the frustum cull sphere/box block
package fcsb_pkg;

	localparam int NUM_PLANES = 6;
	localparam int PLANE_W    = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int COORD_W    = 20;
	localparam int OP_W       = COORD_W + 1;
	localparam int NORM_W     = 14;
	localparam int WOFF_W     = 22;
	localparam int PROD_W     = NORM_W + OP_W;
	localparam int QPROD_W    = NORM_W + 1 + OP_W;
	localparam int SUM_W      = 40;

	localparam int NX_LSB = 0;
	localparam int NY_LSB = 14;
	localparam int NZ_LSB = 28;
	localparam int W_LSB  = 42;

	localparam int SPHERE_W_SH = 12;
	localparam int BOX_W_SH    = 13;
	localparam int RAD_SH      = 12;

	localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FAR    = 3'd5;

	localparam logic FUNC_SPHERE = 1'b0;
	localparam logic FUNC_BOX    = 1'b1;

	// operands of one item after the input stage
	typedef struct packed {
		logic                      func;
		logic                      invalid;
		logic signed [OP_W-1:0]    cx;
		logic signed [OP_W-1:0]    cy;
		logic signed [OP_W-1:0]    cz;
		logic signed [OP_W-1:0]    ex;
		logic signed [OP_W-1:0]    ey;
		logic signed [OP_W-1:0]    ez;
		logic signed [COORD_W-1:0] r;
	} op_t;

endpackage

// ===== rtl/fcsb_plane.sv =====
// One plane test: registered products, then sum and sign
module fcsb_plane import fcsb_pkg::*; (
	input  logic               clk,
	input  logic               load,
	input  logic [PLANE_W-1:0] plane,
	input  op_t                op,
	output logic               outside
);

	logic signed [NORM_W-1:0]  n    [3];
	logic signed [NORM_W:0]    next [3];
	logic signed [NORM_W:0]    nabs [3];
	logic signed [OP_W-1:0]    c    [3];
	logic signed [OP_W-1:0]    e    [3];
	logic signed [WOFF_W-1:0]  w;
	logic signed [SUM_W-1:0]   k_d;
	logic signed [PROD_W-1:0]  p_s2 [3];
	logic signed [QPROD_W-1:0] q_s2 [3];
	logic signed [SUM_W-1:0]   k_s2;
	logic signed [SUM_W-1:0]   total;

	always_comb begin
		n[0] = plane[NX_LSB +: NORM_W];
		n[1] = plane[NY_LSB +: NORM_W];
		n[2] = plane[NZ_LSB +: NORM_W];
		w    = plane[W_LSB +: WOFF_W];
		c[0] = op.cx;
		c[1] = op.cy;
		c[2] = op.cz;
		e[0] = op.ex;
		e[1] = op.ey;
		e[2] = op.ez;
		for (int k = 0; k < 3; k++) begin
			next[k] = (NORM_W+1)'(n[k]);
			nabs[k] = next[k][NORM_W] ? -next[k] : next[k];
		end
		if (op.func == FUNC_BOX) begin
			k_d = SUM_W'(w) <<< BOX_W_SH;
		end else begin
			k_d = (SUM_W'(w) <<< SPHERE_W_SH) + (SUM_W'(op.r) <<< RAD_SH);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < 3; k++) begin
				p_s2[k] <= PROD_W'(n[k]) * PROD_W'(c[k]);
				q_s2[k] <= (op.func == FUNC_BOX) ?
					QPROD_W'(nabs[k]) * QPROD_W'(e[k]) : '0;
			end
			k_s2 <= k_d;
		end
	end

	always_comb begin
		total = SUM_W'(p_s2[0]) + SUM_W'(p_s2[1]) + SUM_W'(p_s2[2])
		      + SUM_W'(q_s2[0]) + SUM_W'(q_s2[1]) + SUM_W'(q_s2[2]) + k_s2;
		outside = total[SUM_W-1];
	end

endmodule

// ===== rtl/frustum_cull_sphere_box.sv =====
// Frustum cull of a bounding sphere or axis-aligned box against six planes.
// One item is accepted per cycle while in_ready is high, and its visible flag
// passes through registered stages: an input stage forms centre sums and
// extent differences, a product stage runs the six plane units in parallel
// (three multipliers each for the signed distance, three more for the box
// radius), and the result stage adds each plane's terms and takes the sign.
// The result register holds while the output stalls, and the input keeps
// filling the stages behind it. Plane registers are written through the configuration
// channel, which is always ready; they should change only while no item is in flight.
`include "frustum_cull_sphere_box_defines.svh"

module frustum_cull_sphere_box import fcsb_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [PLANE_W-1:0]        cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      func,
	input  logic signed [COORD_W-1:0] a_x,
	input  logic signed [COORD_W-1:0] a_y,
	input  logic signed [COORD_W-1:0] a_z,
	input  logic signed [COORD_W-1:0] b_x,
	input  logic signed [COORD_W-1:0] b_y,
	input  logic signed [COORD_W-1:0] b_z,
	input  logic signed [COORD_W-1:0] sphere_radius,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      visible
);

	logic [PLANE_W-1:0]     plane_q [NUM_PLANES];
	op_t                    op_d;
	op_t                    op_s1;
	logic                   vld_s1;
	logic                   vld_s2;
	logic                   inv_s2;
	logic                   vld_s3;
	logic                   vis_s3;
	logic                   en1;
	logic                   en2;
	logic                   en3;
	logic [NUM_PLANES-1:0]  outside;
	logic signed [OP_W-1:0] ax;
	logic signed [OP_W-1:0] ay;
	logic signed [OP_W-1:0] az;
	logic signed [OP_W-1:0] bx;
	logic signed [OP_W-1:0] by;
	logic signed [OP_W-1:0] bz;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				plane_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_index <= REG_FAR) begin
			plane_q[cfg_index] <= cfg_data;
		end
	end

	assign en3      = !vld_s3 || out_ready;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	always_comb begin
		ax = OP_W'(a_x);
		ay = OP_W'(a_y);
		az = OP_W'(a_z);
		bx = OP_W'(b_x);
		by = OP_W'(b_y);
		bz = OP_W'(b_z);
		op_d.func = func;
		op_d.r    = sphere_radius;
		op_d.ex   = bx - ax;
		op_d.ey   = by - ay;
		op_d.ez   = bz - az;
		if (func == FUNC_BOX) begin
			op_d.cx = ax + bx;
			op_d.cy = ay + by;
			op_d.cz = az + bz;
		end else begin
			op_d.cx = ax;
			op_d.cy = ay;
			op_d.cz = az;
		end
		op_d.invalid = (func == FUNC_BOX) &&
			(op_d.ex[OP_W-1] || op_d.ey[OP_W-1] || op_d.ez[OP_W-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= in_valid;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
			if (en3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1 <= op_d;
		end
		if (en2) begin
			inv_s2 <= op_s1.invalid;
		end
		if (en3) begin
			vis_s3 <= !inv_s2 && !(|outside);
		end
	end

	for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
		fcsb_plane u_plane (
			.clk     (clk),
			.load    (en2),
			.plane   (plane_q[g]),
			.op      (op_s1),
			.outside (outside[g])
		);
	end

	assign out_valid = vld_s3;
	assign visible   = vis_s3;

	// hold an invalid box as culled
	`FCSB_ASSERT_NXT(a_invalid_culled, vld_s2 && inv_s2 && en3, !visible, "invalid box shown visible")
	// drop no item when every stage is full and the output stalls
	`FCSB_ASSERT_IMP(a_full_stall, vld_s1 && vld_s2 && vld_s3 && !out_ready, !in_ready, "input taken while full")
	// advance only items that came through the product stage
	`FCSB_ASSERT_IMP(a_out_source, $rose(out_valid), $past(vld_s2), "result with no item behind it")

endmodule
